// ===== src/pwd_pkg.sv =====
// pwd_pkg: shared types, widths, register indexes and state codes for the
// pid controller with dead zone and integral separation; no dependencies
package pwd_pkg;

  localparam int GainFracBits   = 8;
  localparam int DerivFilterQ16 = 0;

  localparam int MulBits  = 16;
  localparam int ErrW     = 18;
  localparam int DiffW    = ErrW + 1;
  localparam int PW       = MulBits + ErrW;
  localparam int DW       = MulBits + DiffW;
  localparam int IntegW   = 16 + GainFracBits;
  localparam int IsumW    = PW + 1;
  localparam int DTermW   = DW;
  localparam int FiltW    = DTermW + MulBits + 3;
  localparam int PdSumW   = DW + 1;
  localparam int SumW     = PdSumW + 1;
  localparam int RndAdd   = (GainFracBits == 0) ? 0 : (1 << (GainFracBits - 1));
  localparam int FiltRnd  = 1 << (MulBits - 1);
  localparam int CntW     = $clog2(MulBits);
  localparam int CfgIdxW  = 8;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] measurement;
    logic signed [15:0] setpoint;
  } pwd_in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               integral_applied;
  } pwd_out_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN        = 8'd0,
    REG_INTEG_GAIN       = 8'd1,
    REG_DERIV_GAIN       = 8'd2,
    REG_DRIVE_LIMIT      = 8'd3,
    REG_INTEG_LIMIT      = 8'd4,
    REG_DEAD_ZONE        = 8'd5,
    REG_SEPARATION_LIMIT = 8'd6,
    REG_WRAP_SPAN        = 8'd7
  } pwd_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_WRAP,
    ST_DZ,
    ST_LOAD,
    ST_MUL,
    ST_FLOAD,
    ST_FILT,
    ST_INT,
    ST_SUM,
    ST_RND,
    ST_OUT
  } pwd_state_t;

endpackage

// ===== src/pwd_smul.sv =====
// pwd_smul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on pwd_pkg for the multiplier width
module pwd_smul import pwd_pkg::*; #(
  parameter int W = 34
) (
  input  logic                clk,
  input  logic                start,
  input  logic signed [W-1:0] init,
  input  logic signed [W-1:0] mcand,
  input  logic [MulBits-1:0]  mult,
  output logic signed [W-1:0] prod
);

  logic signed [W-1:0] acc_r, acc_nxt;
  logic signed [W-1:0] mcand_r, mcand_nxt;
  logic [MulBits-1:0]  mult_r, mult_nxt;

  always_comb begin
    if (start) begin
      acc_nxt   = init;
      mcand_nxt = mcand;
      mult_nxt  = mult;
    end else begin
      acc_nxt   = mult_r[0] ? acc_r + mcand_r : acc_r;
      mcand_nxt = mcand_r <<< 1;
      mult_nxt  = mult_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
  end

  assign prod = acc_r;

endmodule

// ===== src/pid_with_deadzone_and_separation.sv =====
// pid_with_deadzone_and_separation: positional pid controller top level
// depends on pwd_pkg and pwd_smul
//
// usage: a word on in_data (operation, measurement, setpoint) is taken when
// in_valid and in_ready are high; one result word (drive, integral_applied)
// leaves on out_data under out_valid/out_ready. a clear word zeroes the
// error history and integrator, keeps the last derivative term and returns
// a zero result. registers are written on cfg_index/cfg_data under
// cfg_valid/cfg_ready (always ready); indexes past the list are ignored.
// write registers only while no word is in flight.
// sequence: a control word passes the subtract, wrap, dead zone and load
// states, the bit-serial gain products, the filter load and filter product
// when the derivative filter is enabled, then integrate, sum, round and out;
// a clear word goes from subtract straight to out. a new word is taken only
// once the previous one has left its out state.
// one word is in work at a time; a finished result sits in the output
// register so the next word is accepted while it waits. if the receiver
// stalls, a second result holds in its last step until the output register
// frees. synchronous reset (rst_n low) restores register defaults and
// clears history, integrator and derivative term.
module pid_with_deadzone_and_separation import pwd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pwd_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pwd_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  pwd_state_t state_r, state_nxt;

  logic [15:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [14:0] drive_limit_r, integ_limit_r;
  logic [15:0] dead_zone_r, separation_limit_r, wrap_span_r;

  pwd_in_t                  in_r;
  logic signed [ErrW-1:0]   err_r;
  logic signed [DiffW-1:0]  diff_r;
  logic                     sep_r;
  logic signed [ErrW-1:0]   prev_error_r;
  logic signed [IntegW-1:0] integ_r;
  logic signed [DTermW-1:0] pd_r;
  logic signed [PdSumW-1:0] pdsum_r;
  logic signed [SumW-1:0]   sum_r;
  pwd_out_t                 res_r;
  pwd_out_t                 out_data_r;
  logic                     out_valid_r;
  logic [CntW-1:0]          cnt_r;

  logic start_mul, start_filt, out_load;

  logic signed [PW-1:0]     p_prod, i_prod;
  logic signed [DW-1:0]     d_prod;
  logic signed [FiltW-1:0]  f_prod, f_init, f_mcand, f_rnd;

  logic signed [ErrW-1:0]   sub_err, wrap_err;
  logic signed [ErrW:0]     e2, span_s;
  logic [ErrW-1:0]          mag;
  logic                     dz;
  logic signed [IsumW-1:0]  isum;
  logic signed [IntegW-1:0] ilim, integ_clamp;
  logic signed [DTermW-1:0] dterm;
  logic signed [SumW:0]     rnd;
  logic signed [16:0]       dlim;
  logic signed [15:0]       drive_clamp;

  // bit-serial multipliers
  pwd_smul #(.W(PW)) u_pmul (
    .clk(clk), .start(start_mul), .init('0),
    .mcand(PW'(err_r)), .mult(prop_gain_r), .prod(p_prod)
  );

  pwd_smul #(.W(PW)) u_imul (
    .clk(clk), .start(start_mul), .init('0),
    .mcand(PW'(err_r)), .mult(integ_gain_r), .prod(i_prod)
  );

  pwd_smul #(.W(DW)) u_dmul (
    .clk(clk), .start(start_mul), .init('0),
    .mcand(DW'(diff_r)), .mult(deriv_gain_r), .prod(d_prod)
  );

  // filter: d*65536 + g*(prev_d - d)
  assign f_init  = FiltW'(d_prod) <<< MulBits;
  assign f_mcand = FiltW'(pd_r) - FiltW'(d_prod);

  pwd_smul #(.W(FiltW)) u_fmul (
    .clk(clk), .start(start_filt), .init(f_init),
    .mcand(f_mcand), .mult(MulBits'(DerivFilterQ16)), .prod(f_prod)
  );

  // datapath arithmetic
  always_comb begin
    sub_err = ErrW'(in_r.setpoint) - ErrW'(in_r.measurement);

    e2       = (ErrW+1)'(err_r) <<< 1;
    span_s   = $signed({3'b000, wrap_span_r});
    wrap_err = err_r;
    if (wrap_span_r != '0) begin
      if (e2 > span_s) begin
        wrap_err = err_r - ErrW'(span_s);
      end else if (e2 < -span_s) begin
        wrap_err = err_r + ErrW'(span_s);
      end
    end

    mag = err_r[ErrW-1] ? ErrW'(-err_r) : ErrW'(err_r);
    dz  = mag < {2'b00, dead_zone_r};

    isum = IsumW'(integ_r) + IsumW'(i_prod);
    ilim = $signed({1'b0, integ_limit_r, {GainFracBits{1'b0}}});
    if (isum > IsumW'(ilim)) begin
      integ_clamp = ilim;
    end else if (isum < -IsumW'(ilim)) begin
      integ_clamp = -ilim;
    end else begin
      integ_clamp = IntegW'(isum);
    end

    f_rnd = (f_prod + FiltW'(FiltRnd)) >>> MulBits;
    dterm = (DerivFilterQ16 == 0) ? d_prod : DTermW'(f_rnd);

    rnd  = ((SumW+1)'(sum_r) + (SumW+1)'(RndAdd)) >>> GainFracBits;
    dlim = $signed({2'b00, drive_limit_r});
    if (rnd > (SumW+1)'(dlim)) begin
      drive_clamp = 16'(dlim);
    end else if (rnd < -(SumW+1)'(dlim)) begin
      drive_clamp = 16'(-dlim);
    end else begin
      drive_clamp = 16'(rnd);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SUB;
      ST_SUB:   state_nxt = in_r.operation ? ST_OUT : ST_WRAP;
      ST_WRAP:  state_nxt = ST_DZ;
      ST_DZ:    state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_r == CntW'(MulBits - 1)) begin
          state_nxt = (DerivFilterQ16 != 0) ? ST_FLOAD : ST_INT;
        end
      end
      ST_FLOAD: state_nxt = ST_FILT;
      ST_FILT:  if (cnt_r == CntW'(MulBits - 1)) state_nxt = ST_INT;
      ST_INT:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    start_mul  = 1'b0;
    start_filt = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_LOAD:  start_mul = 1'b1;
      ST_FLOAD: start_filt = 1'b1;
      ST_OUT:   out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r        <= '0;
      integ_gain_r       <= '0;
      deriv_gain_r       <= '0;
      drive_limit_r      <= 15'h7fff;
      integ_limit_r      <= 15'h7fff;
      dead_zone_r        <= '0;
      separation_limit_r <= 16'hffff;
      wrap_span_r        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:        prop_gain_r        <= cfg_data;
        REG_INTEG_GAIN:       integ_gain_r       <= cfg_data;
        REG_DERIV_GAIN:       deriv_gain_r       <= cfg_data;
        REG_DRIVE_LIMIT:      drive_limit_r      <= cfg_data[14:0];
        REG_INTEG_LIMIT:      integ_limit_r      <= cfg_data[14:0];
        REG_DEAD_ZONE:        dead_zone_r        <= cfg_data;
        REG_SEPARATION_LIMIT: separation_limit_r <= cfg_data;
        REG_WRAP_SPAN:        wrap_span_r        <= cfg_data;
        default:              ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      integ_r      <= '0;
      pd_r         <= '0;
    end else begin
      if (state_r == ST_SUB && in_r.operation) begin
        prev_error_r <= '0;
        integ_r      <= '0;
      end else if (state_r == ST_INT) begin
        prev_error_r <= err_r;
        integ_r      <= integ_clamp;
        pd_r         <= dterm;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    unique case (state_r)
      ST_SUB: begin
        err_r <= sub_err;
        res_r <= '0;
      end
      ST_WRAP: err_r <= wrap_err;
      ST_DZ: begin
        err_r  <= dz ? '0 : err_r;
        diff_r <= dz ? '0 : DiffW'(err_r) - DiffW'(prev_error_r);
        sep_r  <= dz || (mag <= {2'b00, separation_limit_r});
      end
      ST_INT:  pdsum_r <= PdSumW'(p_prod) + PdSumW'(dterm);
      ST_SUM:  sum_r <= SumW'(pdsum_r) + (sep_r ? SumW'(integ_r) : '0);
      ST_RND: begin
        res_r.drive            <= drive_clamp;
        res_r.integral_applied <= sep_r;
      end
      default: ;
    endcase
  end

  // step counter for the serial multipliers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_mul || start_filt) begin
      cnt_r <= '0;
    end else if (state_r == ST_MUL || state_r == ST_FILT) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((17'(out_data_r.drive) <= dlim) && (17'(out_data_r.drive) >= -dlim)))
    else $error("drive outside drive limit");

  a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> ((integ_r <= ilim) && (integ_r >= -ilim)))
    else $error("integrator outside its limit");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB && in_r.operation) |=>
      ((prev_error_r == '0) && (integ_r == '0) && (res_r == '0) && (state_r == ST_OUT)))
    else $error("clear did not zero history and result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !out_load) |=> (state_r == ST_OUT && out_valid_r))
    else $error("result left before output register freed");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for pid_with_deadzone_and_separation, directed
// corner words then randomized tuning phases under random valid/ready gaps
// depends on pwd_pkg and the pid_with_deadzone_and_separation rtl
module tb;
  import pwd_pkg::*;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_INDEX = '1;
  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 100;
  localparam int TuningPhases = 15;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  pwd_in_t            in_data;
  logic               out_valid;
  logic               out_ready;
  pwd_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [15:0]        cfg_data;

  // controller copy: tuning and history
  longint cfg_prop = 0;
  longint cfg_integ = 0;
  longint cfg_deriv = 0;
  longint cfg_drive_lim = 32767;
  longint cfg_integ_lim = 32767;
  longint cfg_dead_zone = 0;
  longint cfg_sep_lim = 65535;
  longint cfg_wrap = 0;
  longint err_hist = 0;
  longint integ_acc = 0;
  longint deriv_hist = 0;

  pwd_out_t pending_drives [$];
  pwd_out_t due_word;
  int       mismatches = 0;
  int       cycle_cnt = 0;
  int       gap_max = 0;
  int       stall_max = 0;

  pid_with_deadzone_and_separation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint mag_of(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint sat_sym(input longint x, input longint lim);
    if (x > lim) begin
      return lim;
    end
    if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

  function automatic longint rshift_round(input longint x, input int s);
    if (s == 0) begin
      return x;
    end
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic pwd_out_t pid_drive_calc(input pwd_in_t w);
    longint   err;
    longint   prev;
    longint   dterm;
    longint   sum;
    longint   drv;
    logic     sep_in;
    pwd_out_t res;
    res = '0;
    if (w.operation == OP_CLEAR) begin
      err_hist  = 0;
      integ_acc = 0;
      return res;
    end
    err = longint'($signed(w.setpoint)) - longint'($signed(w.measurement));
    if (cfg_wrap != 0) begin
      if (2 * err > cfg_wrap) begin
        err -= cfg_wrap;
      end else if (2 * err < -cfg_wrap) begin
        err += cfg_wrap;
      end
    end
    prev = err_hist;
    if (mag_of(err) < cfg_dead_zone) begin
      err  = 0;
      prev = 0;
    end
    sep_in    = !(mag_of(err) > cfg_sep_lim);
    integ_acc = sat_sym(integ_acc + cfg_integ * err, cfg_integ_lim <<< GainFracBits);
    dterm = rshift_round(cfg_deriv * (err - prev) * (65536 - DerivFilterQ16)
                         + longint'(DerivFilterQ16) * deriv_hist, 16);
    sum = cfg_prop * err + (sep_in ? integ_acc : 0) + dterm;
    drv = sat_sym(rshift_round(sum, GainFracBits), cfg_drive_lim);
    err_hist   = err;
    deriv_hist = dterm;
    res.drive            = drv[15:0];
    res.integral_applied = sep_in;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  task automatic send_word(input logic op, input int meas, input int sp);
    int      gap;
    pwd_in_t w;
    gap           = $urandom_range(gap_max, 0);
    w.operation   = op;
    w.measurement = 16'(meas);
    w.setpoint    = 16'(sp);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_drives.push_back(pid_drive_calc(w));
    @(negedge clk);
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PROP_GAIN:        cfg_prop = val & 16'hffff;
      REG_INTEG_GAIN:       cfg_integ = val & 16'hffff;
      REG_DERIV_GAIN:       cfg_deriv = val & 16'hffff;
      REG_DRIVE_LIMIT:      cfg_drive_lim = val & 15'h7fff;
      REG_INTEG_LIMIT:      cfg_integ_lim = val & 15'h7fff;
      REG_DEAD_ZONE:        cfg_dead_zone = val & 16'hffff;
      REG_SEPARATION_LIMIT: cfg_sep_lim = val & 16'hffff;
      REG_WRAP_SPAN:        cfg_wrap = val & 16'hffff;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input int p, input int i, input int d, input int dl,
                              input int il, input int dz, input int sep, input int wr);
    settle_outputs();
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_DRIVE_LIMIT, dl);
    write_reg(REG_INTEG_LIMIT, il);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_SEPARATION_LIMIT, sep);
    write_reg(REG_WRAP_SPAN, wr);
    // past the register list, must leave everything alone
    write_reg(REG_UNUSED_INDEX, $urandom_range(65535));
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_value(input int top, input int low_span);
    case ($urandom_range(5))
      0:       return 0;
      1:       return top;
      2, 3:    return $urandom_range(low_span);
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic test_reset_defaults();
    gap_max   = 0;
    stall_max = 0;
    send_word(OP_STEP, -32768, 32767);
    send_word(OP_CLEAR, 32767, -32768);
    send_word(OP_STEP, 32767, -32768);
  endtask

  task automatic test_proportional_extremes();
    program_regs(65535, 0, 0, 32767, 32767, 0, 65535, 0);
    gap_max   = 6;
    stall_max = 6;
    send_word(OP_STEP, -32768, 32767);
    send_word(OP_STEP, 32767, -32768);
    send_word(OP_STEP, 0, 0);
    send_word(OP_STEP, 0, 1);
    send_word(OP_STEP, 0, -1);
  endtask

  task automatic test_wrap_deadzone_separation();
    program_regs(256, 128, 512, 1000, 100, 10, 50, 360);
    send_word(OP_STEP, 0, 200);
    send_word(OP_STEP, 0, -200);
    send_word(OP_STEP, 0, 180);
    send_word(OP_STEP, 100, 105);
    send_word(OP_STEP, 0, 10);
    send_word(OP_STEP, 0, 50);
    send_word(OP_STEP, 0, 51);
    send_word(OP_CLEAR, 0, 51);
    send_word(OP_STEP, 0, -30);
    send_word(OP_STEP, 32767, -32768);
  endtask

  task automatic test_register_extremes();
    program_regs(65535, 65535, 65535, 0, 0, 65535, 0, 65535);
    send_word(OP_STEP, -32768, 32767);
    send_word(OP_STEP, 32767, -32768);
    send_word(OP_STEP, 0, 32767);
    program_regs(65535, 65535, 65535, 32767, 32767, 0, 0, 0);
    send_word(OP_STEP, -32768, 32767);
    send_word(OP_STEP, 32767, -32768);
    send_word(OP_STEP, 0, 0);
    send_word(OP_CLEAR, -1, -1);
  endtask

  task automatic test_random_tuning();
    int kind;
    int meas;
    for (int ph = 0; ph < TuningPhases; ph++) begin
      program_regs(pick_value(65535, 1023), pick_value(65535, 1023),
                   pick_value(65535, 1023), pick_value(32767, 255),
                   pick_value(32767, 255), pick_value(65535, 63),
                   pick_value(65535, 2000), pick_value(65535, 4096));
      // every fourth phase runs with no gaps on either side
      gap_max   = (ph % 4 == 0) ? 0 : 6;
      stall_max = (ph % 4 == 0) ? 0 : 6;
      for (int n = 0; n < PhaseWords; n++) begin
        kind = $urandom_range(19);
        meas = int'($urandom_range(65535)) - 32768;
        if (kind == 0) begin
          send_word(OP_CLEAR, $urandom, $urandom);
        end else if (kind < 8) begin
          send_word(OP_STEP, meas, $urandom_range(65535));
        end else begin
          send_word(OP_STEP, meas, meas + int'($urandom_range(400)) - 200);
        end
      end
    end
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = $urandom_range(stall_max, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word, drive %0d", out_data.drive));
      end else begin
        due_word = pending_drives.pop_front();
        if (out_data.drive !== due_word.drive) begin
          flag_mismatch($sformatf("drive got %0d want %0d",
                                  out_data.drive, due_word.drive));
        end
        if (out_data.integral_applied !== due_word.integral_applied) begin
          flag_mismatch($sformatf("integral_applied got %b want %b",
                                  out_data.integral_applied, due_word.integral_applied));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_proportional_extremes();
    test_wrap_deadzone_separation();
    test_register_extremes();
    test_random_tuning();
    settle_outputs();
    // watch for stray result words
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
